// ===== hw/rtl/mau_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Shared widths, action codes and reducer types.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int unsigned RESIDUE_WIDTH = 30;
  localparam int unsigned OPERAND_WIDTH = 64;
  localparam int unsigned LEN_WIDTH     = $clog2(OPERAND_WIDTH + 1);
  localparam int unsigned ACTION_WIDTH  = 3;

  localparam logic [RESIDUE_WIDTH-1:0] MODULUS_RESET = RESIDUE_WIDTH'(998244353);

  typedef enum logic [ACTION_WIDTH-1:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_POW = 3'd4
  } action_e;

  typedef struct packed {
    logic                      start;
    logic [OPERAND_WIDTH-1:0]  value;
    logic [LEN_WIDTH-1:0]      len;
    logic [RESIDUE_WIDTH-1:0]  modulus;
    logic                      neg;
  } red_req_t;

endpackage

// ===== hw/rtl/modular_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Add, subtract, multiply, divide and power over a prime modulus.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start_i with action_i, operand_a_i and operand_b_i while busy_o is
//   low; the item is taken at that edge and busy_o stays high until the
//   result is shown. result_o is valid for exactly one cycle with
//   result_valid_o; the receiver cannot stall it.
//   cfg_we_i/cfg_wdata_i write the modulus; write only while idle.
//   All work runs through one bit-serial reducer (one bit per cycle) and
//   one registered multiplier under a sequencer.
//   Steps: reduce a, then b; add and subtract finish there, multiply
//   adds a multiply-reduce pass. Power and divide add up to two
//   multiply-reduce passes per exponent bit; divide ends with a
//   multiply-reduce pass by a. One item at a time.
//   Reset: sequencer idle, modulus set to 998244353.
//   A modulus below two or an unused action gives a result of 0.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  output logic                                     busy_o,
  input  logic [mau_pkg::ACTION_WIDTH-1:0]         action_i,
  input  logic signed [mau_pkg::OPERAND_WIDTH-1:0] operand_a_i,
  input  logic signed [mau_pkg::OPERAND_WIDTH-1:0] operand_b_i,
  output logic [mau_pkg::RESIDUE_WIDTH-1:0]        result_o,
  output logic                                     result_valid_o,
  input  logic                                     cfg_we_i,
  input  logic [mau_pkg::RESIDUE_WIDTH-1:0]        cfg_wdata_i
);

  localparam int unsigned W  = mau_pkg::RESIDUE_WIDTH;
  localparam int unsigned OW = mau_pkg::OPERAND_WIDTH;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RA    = 8'b0000_0010,
    S_RB    = 8'b0000_0100,
    S_PCHK  = 8'b0000_1000,
    S_PLOOP = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_MRED  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  typedef enum logic [2:0] {
    P_PLAIN = 3'b001,
    P_ACC   = 3'b010,
    P_SQR   = 3'b100
  } purpose_e;

  state_e             state_q, state_d;
  purpose_e           pur_q, pur_d;
  logic [W-1:0]       p_q;
  logic [mau_pkg::ACTION_WIDTH-1:0] act_q, act_d;
  logic [OW-1:0]      opb_q, opb_d;
  logic [W-1:0]       a_q, a_d, base_q, base_d, acc_q, acc_d, e_q, e_d;
  logic [W-1:0]       mx_q, mx_d, my_q, my_d, res_q, res_d;
  logic [2*W-1:0]     prod;
  logic               div_q, div_d;
  mau_pkg::red_req_t  req_q, req_d;
  logic               red_done;
  logic [W-1:0]       red_rem;
  logic [W:0]         sum;
  logic [W-1:0]       pm1, fix;

  mau_reduce u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .done_o (red_done),
    .rem_o  (red_rem)
  );

  assign pm1  = p_q - 1'b1;
  assign prod = mx_q * my_q;

  always_comb begin
    state_d = state_q;
    pur_d   = pur_q;
    act_d   = act_q;
    opb_d   = opb_q;
    a_d     = a_q;
    base_d  = base_q;
    acc_d   = acc_q;
    e_d     = e_q;
    mx_d    = mx_q;
    my_d    = my_q;
    res_d   = res_q;
    div_d   = div_q;
    req_d   = req_q;
    req_d.start = 1'b0;
    sum     = '0;
    fix     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          act_d = action_i;
          opb_d = operand_b_i;
          if (p_q < W'(2) || action_i > mau_pkg::ACT_POW) begin
            res_d   = '0;
            state_d = S_DONE;
          end else begin
            req_d.start   = 1'b1;
            req_d.value   = operand_a_i[OW-1] ? OW'(0) - operand_a_i : operand_a_i;
            req_d.neg     = operand_a_i[OW-1];
            req_d.len     = mau_pkg::LEN_WIDTH'(OW);
            req_d.modulus = p_q;
            state_d       = S_RA;
          end
        end
      end
      S_RA: begin
        if (red_done) begin
          a_d           = red_rem;
          req_d.start   = 1'b1;
          req_d.value   = opb_q[OW-1] ? OW'(0) - opb_q : opb_q;
          req_d.neg     = opb_q[OW-1];
          req_d.len     = mau_pkg::LEN_WIDTH'(OW);
          req_d.modulus = (act_q == mau_pkg::ACT_POW) ? pm1 : p_q;
          state_d       = S_RB;
        end
      end
      S_RB: begin
        if (red_done) begin
          div_d = 1'b0;
          acc_d = W'(1);
          unique case (act_q)
            mau_pkg::ACT_ADD, mau_pkg::ACT_SUB: begin
              sum = (act_q == mau_pkg::ACT_ADD)
                  ? {1'b0, a_q} + {1'b0, red_rem}
                  : {1'b0, a_q} + {1'b0, p_q} - {1'b0, red_rem};
              fix = (sum >= {1'b0, p_q}) ? W'(sum - {1'b0, p_q}) : W'(sum);
              res_d   = fix;
              state_d = S_DONE;
            end
            mau_pkg::ACT_MUL: begin
              mx_d    = a_q;
              my_d    = red_rem;
              pur_d   = P_PLAIN;
              state_d = S_MUL;
            end
            mau_pkg::ACT_DIV: begin
              div_d   = 1'b1;
              base_d  = red_rem;
              e_d     = (p_q == W'(2)) ? '0 : p_q - W'(2);
              state_d = S_PCHK;
            end
            default: begin
              base_d  = a_q;
              e_d     = red_rem;
              state_d = S_PCHK;
            end
          endcase
        end
      end
      S_PCHK: begin
        if (base_q == '0 || base_q == W'(1) || e_q == '0) begin
          fix = (base_q == '0) ? '0 : W'(1);
          if (div_q) begin
            mx_d    = a_q;
            my_d    = fix;
            pur_d   = P_PLAIN;
            state_d = S_MUL;
          end else begin
            res_d   = fix;
            state_d = S_DONE;
          end
        end else begin
          state_d = S_PLOOP;
        end
      end
      S_PLOOP: begin
        if (e_q == '0) begin
          if (div_q) begin
            mx_d    = a_q;
            my_d    = acc_q;
            pur_d   = P_PLAIN;
            state_d = S_MUL;
          end else begin
            res_d   = acc_q;
            state_d = S_DONE;
          end
        end else if (e_q[0]) begin
          mx_d    = acc_q;
          my_d    = base_q;
          pur_d   = P_ACC;
          state_d = S_MUL;
        end else begin
          mx_d    = base_q;
          my_d    = base_q;
          pur_d   = P_SQR;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        req_d.start   = 1'b1;
        req_d.value   = OW'(prod) << (OW - 2 * W);
        req_d.neg     = 1'b0;
        req_d.len     = mau_pkg::LEN_WIDTH'(2 * W);
        req_d.modulus = p_q;
        state_d       = S_MRED;
      end
      S_MRED: begin
        if (red_done) begin
          unique case (pur_q)
            P_ACC: begin
              acc_d   = red_rem;
              mx_d    = base_q;
              my_d    = base_q;
              pur_d   = P_SQR;
              state_d = S_MUL;
            end
            P_SQR: begin
              base_d  = red_rem;
              e_d     = e_q >> 1;
              state_d = S_PLOOP;
            end
            default: begin
              res_d   = red_rem;
              state_d = S_DONE;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pur_q   <= P_PLAIN;
      p_q     <= mau_pkg::MODULUS_RESET;
      req_q   <= '0;
      div_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pur_q   <= pur_d;
      req_q   <= req_d;
      div_q   <= div_d;
      if (cfg_we_i) begin
        p_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    opb_q  <= opb_d;
    a_q    <= a_d;
    base_q <= base_d;
    acc_q  <= acc_d;
    e_q    <= e_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    res_q  <= res_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_DONE);
  assign result_o       = res_q;

endmodule

// ===== hw/rtl/mau_reduce.sv =====
// ----------------------------------------------------------------------------
// Modular reducer
// Bit-serial floor remainder of a left-aligned magnitude by a variable
// modulus, one bit per cycle, with sign fix-up at the end.
// ----------------------------------------------------------------------------
module mau_reduce (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mau_pkg::red_req_t                 req_i,
  output logic                              done_o,
  output logic [mau_pkg::RESIDUE_WIDTH-1:0] rem_o
);

  logic [mau_pkg::OPERAND_WIDTH-1:0] sh_q;
  logic [mau_pkg::RESIDUE_WIDTH-1:0] r_q, m_q, r_step;
  logic [mau_pkg::LEN_WIDTH-1:0]     cnt_q;
  logic                              run_q, done_q, neg_q;
  logic [mau_pkg::RESIDUE_WIDTH:0]   trial, diff;

  always_comb begin
    trial  = {r_q, sh_q[mau_pkg::OPERAND_WIDTH-1]};
    diff   = trial - {1'b0, m_q};
    r_step = (trial >= {1'b0, m_q}) ? diff[mau_pkg::RESIDUE_WIDTH-1:0]
                                     : trial[mau_pkg::RESIDUE_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      sh_q   <= '0;
      r_q    <= '0;
      m_q    <= '0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
    end else if (req_i.start) begin
      sh_q   <= req_i.value;
      r_q    <= '0;
      m_q    <= req_i.modulus;
      cnt_q  <= req_i.len;
      neg_q  <= req_i.neg;
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      sh_q  <= sh_q << 1;
      r_q   <= r_step;
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == mau_pkg::LEN_WIDTH'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign rem_o  = (neg_q && r_q != '0) ? m_q - r_q : r_q;

endmodule

// ===== hw/rtl/mau_checker.sv =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit checker
// Port-level checks of the command handshake and result strobe.
// ----------------------------------------------------------------------------
module mau_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic result_valid_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("item accepted without going busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o && !busy_o)
    else $error("result strobe not followed by idle");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !result_valid_o)
    else $error("result strobe while idle");

  a_end_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(result_valid_o))
    else $error("busy dropped without a result");

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o)
);

// ===== dv/mau_checker.sv =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit checker
// Watches accepted items and results, computes the expected residue for each
// item and compares it with the result, in order.
// ----------------------------------------------------------------------------
module mau_scoreboard (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic                                     busy_o,
  input  logic [mau_pkg::ACTION_WIDTH-1:0]         action_i,
  input  logic signed [mau_pkg::OPERAND_WIDTH-1:0] operand_a_i,
  input  logic signed [mau_pkg::OPERAND_WIDTH-1:0] operand_b_i,
  input  logic [mau_pkg::RESIDUE_WIDTH-1:0]        result_o,
  input  logic                                     result_valid_o,
  input  logic                                     cfg_we_i,
  input  logic [mau_pkg::RESIDUE_WIDTH-1:0]        cfg_wdata_i,
  output int                                       fail_count,
  output int                                       pending_count,
  output int                                       result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [mau_pkg::RESIDUE_WIDTH-1:0] prime_q;
  logic [mau_pkg::RESIDUE_WIDTH-1:0] residue_q[$];

  function automatic logic [63:0] floor_mod(logic [63:0] raw, logic [63:0] m);
    logic [63:0] r;
    if (!raw[63]) return raw % m;
    r = (64'd0 - raw) % m;
    return (r != 0) ? m - r : 64'd0;
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] ex,
                                          logic [63:0] m);
    logic [63:0] acc;
    acc = 1;
    if (base == 0) return 0;
    if (base == 1) return 1;
    if (ex == 0) return 1;
    while (ex != 0) begin
      if (ex[0]) acc = (acc * base) % m;
      base = (base * base) % m;
      ex = ex >> 1;
    end
    return acc % m;
  endfunction

  function automatic logic [mau_pkg::RESIDUE_WIDTH-1:0] modular_result(
      logic [mau_pkg::RESIDUE_WIDTH-1:0] pm, logic [2:0] act, logic [63:0] ra,
      logic [63:0] rb);
    logic [63:0] p, a, b, r;
    p = 64'(pm);
    r = 0;
    if (p < 2) return '0;
    a = floor_mod(ra, p);
    b = floor_mod(rb, p);
    case (act)
      mau_pkg::ACT_ADD: r = (a + b) % p;
      mau_pkg::ACT_SUB: r = (a + p - b) % p;
      mau_pkg::ACT_MUL: r = (a * b) % p;
      mau_pkg::ACT_DIV:
        r = (a * pow_mod(b, floor_mod(64'hFFFF_FFFF_FFFF_FFFF, p - 1), p)) % p;
      mau_pkg::ACT_POW: r = pow_mod(a, floor_mod(rb, p - 1), p);
      default: r = 0;
    endcase
    return mau_pkg::RESIDUE_WIDTH'(r);
  endfunction

  assign pending_count = residue_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= mau_pkg::MODULUS_RESET;
      fail_count <= 0;
      result_count <= 0;
      residue_q.delete();
    end else begin
      if (cfg_we_i) prime_q <= cfg_wdata_i;
      if (start_i && !busy_o)
        residue_q.push_back(modular_result(prime_q, action_i, operand_a_i, operand_b_i));
      if (result_valid_o) begin
        result_count <= result_count + 1;
        if (residue_q.size() == 0) begin
          $error("result %0d with no item waiting", result_o);
          fail_count <= fail_count + 1;
        end else begin
          if (result_o !== residue_q[0]) begin
            $error("result: expected %0d, actual %0d", residue_q[0], result_o);
            fail_count <= fail_count + 1;
          end
          void'(residue_q.pop_front());
        end
      end
    end
  end
endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit testbench
// Directed and random items across several moduli, with random sender gaps;
// the checker predicts every residue and the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                                     clk_i;
  logic                                     rst_ni;
  logic                                     start_i;
  logic                                     busy_o;
  logic [mau_pkg::ACTION_WIDTH-1:0]         action_i;
  logic signed [mau_pkg::OPERAND_WIDTH-1:0] operand_a_i;
  logic signed [mau_pkg::OPERAND_WIDTH-1:0] operand_b_i;
  logic [mau_pkg::RESIDUE_WIDTH-1:0]        result_o;
  logic                                     result_valid_o;
  logic                                     cfg_we_i;
  logic [mau_pkg::RESIDUE_WIDTH-1:0]        cfg_wdata_i;
  int                                       fail_count;
  int                                       pending_count;
  int                                       result_count;
  int                                       item_count;
  logic                                     idle_en;

  modular_arithmetic_unit dut (.*);

  mau_scoreboard checker_i (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #2000ms;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(0, 20));
      2: return -64'($urandom_range(0, 20));
      3: return $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 + $urandom_range(0, 3)
                                     : 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
      4: return 64'($urandom);
      default: return -64'($urandom);
    endcase
  endfunction

  task automatic send_item(logic [2:0] act, logic [63:0] a, logic [63:0] b);
    start_i <= 1'b1;
    action_i <= act;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (busy_o);
    item_count++;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0 || busy_o) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_modulus(logic [mau_pkg::RESIDUE_WIDTH-1:0] p);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= p;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_items(int n);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0)
        send_item(3'($urandom_range(5, 7)), rand_operand(), rand_operand());
      else
        send_item(3'($urandom_range(0, 4)), rand_operand(), rand_operand());
    end
  endtask

  initial begin
    logic [mau_pkg::RESIDUE_WIDTH-1:0] primes[6];
    primes = '{2, 3, 1000003, 1073741789, 998244353, 7};
    rst_ni = 1'b0;
    start_i = 1'b0;
    action_i = mau_pkg::ACT_ADD;
    operand_a_i = '0;
    operand_b_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    item_count = 0;
    idle_en = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(mau_pkg::ACT_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    send_item(mau_pkg::ACT_SUB, 0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(mau_pkg::ACT_SUB, -1, 1);
    send_item(mau_pkg::ACT_MUL, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_item(mau_pkg::ACT_MUL, -1, -1);
    send_item(mau_pkg::ACT_DIV, 7, 0);
    send_item(mau_pkg::ACT_DIV, 1, 3);
    send_item(mau_pkg::ACT_DIV, -5, 998244353);
    send_item(mau_pkg::ACT_POW, 0, 0);
    send_item(mau_pkg::ACT_POW, 1, -7);
    send_item(mau_pkg::ACT_POW, 5, 0);
    send_item(mau_pkg::ACT_POW, 3, -1);
    send_item(mau_pkg::ACT_POW, 3, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(mau_pkg::ACT_POW, -2, 64'h8000_0000_0000_0000);
    send_item(mau_pkg::ACT_POW, 998244353, 5);
    send_item(3'd5, 1, 2);
    send_item(3'd7, -1, -1);
    drain();

    foreach (primes[i]) begin
      write_modulus(primes[i]);
      send_item(mau_pkg::ACT_DIV, 1, 1);
      send_item(mau_pkg::ACT_POW, 2, -1);
      random_items(30);
    end
    write_modulus(0);
    send_item(mau_pkg::ACT_ADD, 5, 5);
    send_item(mau_pkg::ACT_POW, 2, 3);
    write_modulus(1);
    send_item(mau_pkg::ACT_MUL, -3, 7);
    write_modulus(30'h3FFF_FFFF);
    random_items(10);
    write_modulus(1073741789);
    random_items(10);
    idle_en = 1'b0;
    random_items(20);
    drain();

    $display("Covered %0d items, %0d results over moduli 0, 1, 2, 3, 7, 1000003,",
             item_count, result_count);
    $display("998244353, 1073741789 and 2^30-1, all actions and operand extremes.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
